// ===== design/aes_pkg.sv =====
package aes_pkg;

  typedef logic [127:0] blk_t;

  typedef struct packed {
    logic dec;
    logic first;
    logic last;
  } rnd_ctrl_t;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_ENC  = 2'd1;
  localparam logic [1:0] ACT_DEC  = 2'd2;

  localparam logic [7:0] SBOX_FWD [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] SBOX_INV [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of the block sits at bits [127-8i -: 8]
  function automatic logic [7:0] get_byte(input blk_t b, input int i);
    get_byte = b[127 - 8 * i -: 8];
  endfunction

  function automatic blk_t byte_subst(input blk_t b, input logic inv);
    blk_t t;
    for (int i = 0; i < 16; i++) begin
      t[127 - 8 * i -: 8] = inv ? SBOX_INV[get_byte(b, i)] : SBOX_FWD[get_byte(b, i)];
    end
    byte_subst = t;
  endfunction

  function automatic blk_t row_rotate(input blk_t b, input logic inv);
    blk_t t;
    int src;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inv ? ((c - r + 4) & 3) : ((c + r) & 3);
        t[127 - 8 * (r + 4 * c) -: 8] = get_byte(b, r + 4 * src);
      end
    end
    row_rotate = t;
  endfunction

  function automatic blk_t mix_cols(input blk_t b);
    blk_t t;
    logic [7:0] p, q, r, s, a;
    for (int c = 0; c < 4; c++) begin
      p = get_byte(b, 4 * c);
      q = get_byte(b, 4 * c + 1);
      r = get_byte(b, 4 * c + 2);
      s = get_byte(b, 4 * c + 3);
      a = p ^ q ^ r ^ s;
      t[127 - 32 * c -: 8]      = p ^ a ^ xtime(p ^ q);
      t[127 - 32 * c - 8 -: 8]  = q ^ a ^ xtime(q ^ r);
      t[127 - 32 * c - 16 -: 8] = r ^ a ^ xtime(r ^ s);
      t[127 - 32 * c - 24 -: 8] = s ^ a ^ xtime(s ^ p);
    end
    mix_cols = t;
  endfunction

  // premultiply that turns MixColumns into InvMixColumns
  function automatic blk_t pre_mul(input blk_t b);
    blk_t t;
    logic [7:0] u, v;
    for (int c = 0; c < 4; c++) begin
      u = xtime(xtime(get_byte(b, 4 * c) ^ get_byte(b, 4 * c + 2)));
      v = xtime(xtime(get_byte(b, 4 * c + 1) ^ get_byte(b, 4 * c + 3)));
      t[127 - 32 * c -: 8]      = get_byte(b, 4 * c) ^ u;
      t[127 - 32 * c - 8 -: 8]  = get_byte(b, 4 * c + 1) ^ v;
      t[127 - 32 * c - 16 -: 8] = get_byte(b, 4 * c + 2) ^ u;
      t[127 - 32 * c - 24 -: 8] = get_byte(b, 4 * c + 3) ^ v;
    end
    pre_mul = t;
  endfunction

endpackage

// ===== design/aes_key_mem.sv =====
module aes_key_mem #(
  parameter int DEPTH  = 60,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  aes_pkg::blk_t     wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output aes_pkg::blk_t     rd_data_r
);

  aes_pkg::blk_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

// ===== design/aes_round.sv =====
module aes_round (
  input  aes_pkg::blk_t     state_in,
  input  aes_pkg::blk_t     rkey,
  input  aes_pkg::rnd_ctrl_t ctrl,
  output aes_pkg::blk_t     state_out
);

  aes_pkg::blk_t enc_t, enc_m, dec_x, dec_y;

  always_comb begin
    enc_t = aes_pkg::row_rotate(aes_pkg::byte_subst(state_in, 1'b0), 1'b0);
    enc_m = ctrl.last ? enc_t : aes_pkg::mix_cols(enc_t);
    dec_x = state_in ^ rkey;
    dec_y = ctrl.first ? dec_x : aes_pkg::mix_cols(aes_pkg::pre_mul(dec_x));
    if (ctrl.dec) begin
      state_out = ctrl.last ? dec_x
                : aes_pkg::byte_subst(aes_pkg::row_rotate(dec_y, 1'b1), 1'b1);
    end else begin
      state_out = ctrl.first ? dec_x : (enc_m ^ rkey);
    end
  end

endmodule

// ===== design/aes_block_cipher_core_unit.sv =====
// Operation: a block request gets the key addition in the round unit, then the rounds, one
//   per cycle, the key store read registered with its address one round ahead; the last
//   round loads the output register, or the block waits in the hold state while it stalls.
//   rounds = clamped round_key_count - 1 (2..14).
// A new block or key load is taken only while the sequencer is idle, not while a block is in work.
// Reset (rst_n low, synchronous): sequencer idle, output empty, key count 11; keys kept.
module aes_block_cipher_core_unit #(
  parameter int KEY_SETS       = 4,
  parameter int MAX_ROUND_KEYS = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [1:0]  in_key_set,
  input  logic [3:0]  in_key_index,
  input  logic [63:0] in_word_high,
  input  logic [63:0] in_word_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_high,
  output logic [63:0] out_result_low
);

  localparam int DEPTH  = KEY_SETS * MAX_ROUND_KEYS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]   state_r, state_nxt;
  logic [3:0]   kcount_r;
  logic [3:0]   cnt_r, cnt_nxt;
  logic [3:0]   rounds_r, rounds_nxt;
  logic         dec_r, dec_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  aes_pkg::blk_t blk_r, blk_nxt;
  logic         out_valid_r, out_valid_nxt;
  aes_pkg::blk_t out_r, out_nxt;

  logic [3:0]   kcount_clamp;
  logic [3:0]   rounds_cfg;
  logic [ADDR_W-1:0] base_in;
  logic         accept, out_free;
  logic         wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [3:0]   next_idx, rd_idx;
  aes_pkg::blk_t rkey, rnd_out;
  aes_pkg::rnd_ctrl_t ctrl;

  // clamp key count to 3..MAX_ROUND_KEYS
  always_comb begin
    kcount_clamp = kcount_r;
    if (kcount_r < 4'd3) kcount_clamp = 4'd3;
    if (kcount_r > 4'(MAX_ROUND_KEYS)) kcount_clamp = 4'(MAX_ROUND_KEYS);
    rounds_cfg = kcount_clamp - 4'd1;
  end

  // key set taken modulo the number of sets
  assign base_in = ADDR_W'((int'(in_key_set) % KEY_SETS) * MAX_ROUND_KEYS);

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // loads with an index past the set are dropped
  assign wr_en   = accept && (in_action == aes_pkg::ACT_LOAD)
                   && (int'(in_key_index) < MAX_ROUND_KEYS);
  assign wr_addr = base_in + ADDR_W'(in_key_index);

  aes_key_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_kmem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   ({in_word_high, in_word_low}),
    .rd_addr   (rd_addr),
    .rd_data_r (rkey)
  );

  assign ctrl.dec   = dec_r;
  assign ctrl.first = (cnt_r == 4'd0);
  assign ctrl.last  = (cnt_r == rounds_r);

  aes_round u_round (
    .state_in  (blk_r),
    .rkey      (rkey),
    .ctrl      (ctrl),
    .state_out (rnd_out)
  );

  // read address runs one step ahead of the round unit
  always_comb begin
    next_idx = cnt_r + 4'd1;
    rd_idx   = dec_r ? (rounds_r - next_idx) : next_idx;
    if (state_r == S_IDLE) begin
      rd_addr = base_in
              + ((in_action == aes_pkg::ACT_DEC) ? ADDR_W'(rounds_cfg) : ADDR_W'(0));
    end else begin
      rd_addr = base_r + ADDR_W'(rd_idx);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rounds_nxt    = rounds_r;
    dec_nxt       = dec_r;
    base_nxt      = base_r;
    blk_nxt       = blk_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_action == aes_pkg::ACT_ENC || in_action == aes_pkg::ACT_DEC)) begin
          state_nxt  = S_RUN;
          cnt_nxt    = 4'd0;
          rounds_nxt = rounds_cfg;
          dec_nxt    = (in_action == aes_pkg::ACT_DEC);
          base_nxt   = base_in;
          blk_nxt    = {in_word_high, in_word_low};
        end
      end
      S_RUN: begin
        blk_nxt = rnd_out;
        cnt_nxt = next_idx;
        if (ctrl.last) begin
          if (out_free) begin
            state_nxt     = S_IDLE;
            out_nxt       = rnd_out;
            out_valid_nxt = 1'b1;
          end else begin
            state_nxt = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        // finished block waits for the output register
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_nxt       = blk_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      kcount_r    <= 4'd11;
      cnt_r       <= 4'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_wr_en) kcount_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rounds_r <= rounds_nxt;
    dec_r    <= dec_nxt;
    base_r   <= base_nxt;
    blk_r    <= blk_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_result_high = out_r[127:64];
  assign out_result_low  = out_r[63:0];

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (cnt_r <= rounds_r))
    else $error("round step past last round");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_RUN || $past(state_r) == S_HOLD))
    else $error("result without a finished block");

  a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOLD) |-> (out_valid_r && in_stall))
    else $error("hold state with free output");

endmodule
